// ===== hw/rtl/tta_pkg.sv =====
`timescale 1ns / 1ps

package tta_pkg;

	// sizes of the set and of the arithmetic
	localparam int MAX_ITEMS   = 256;
	localparam int WEIGHT_BITS = 16;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = $clog2(MAX_ITEMS + 2);
	localparam int N_CELLS     = 3;
	localparam int Q_W         = 16;
	localparam int S_W         = Q_W + 1;
	localparam int DIV_W       = (WEIGHT_BITS > Q_W + 2) ? WEIGHT_BITS : Q_W + 2;
	localparam int STEP_W      = $clog2(Q_W + 1);
	localparam int EXP_W       = 4;
	localparam int ALPHA_W     = 8;
	localparam int STAT_W      = 2;
	localparam int IN_TDATA_W  = ((WEIGHT_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 2 * IDX_W + 2 * ALPHA_W;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_TOO_FEW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TOO_MANY = 2'd2;

	// fixed alphas for a tie or zero margin
	localparam logic [ALPHA_W-1:0] ALPHA_TIE_WIN = 8'd128;
	localparam logic [ALPHA_W-1:0] ALPHA_TIE_RUN = 8'd127;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL    = 8'd255;

	// one ranked entry held by a cell
	typedef struct packed {
		logic                   valid;
		logic [WEIGHT_BITS-1:0] weight;
		logic [IDX_W-1:0]       index;
	} tta_entry_t;

endpackage

// ===== hw/rtl/top_two_alpha_split.sv =====
`timescale 1ns / 1ps

// Top-two alpha split.
// Input stream s_*: one weight per request in s_tdata, s_tlast closes a set.
// Weights are indexed by arrival order and ranked by a row of three cells;
// accepted weights are ranked as taken and stream at one a cycle while collecting.
// After the request with s_tlast the block stops taking weights while it
// forms the result: a compare state, the ratio divide (load, 16 quotient bits,
// hand-off), one multiply of the power per unit of the exponent, the start of
// the share divide and the divide (load, 8 quotient bits, hand-off), then the
// output register loads and m_tvalid rises. A tie or an error status goes from
// the compare straight to the output register. A new set is then taken at once.
// Output stream m_*: one request per set with indices, alphas and the status
// in m_tuser. The result sits in an output register; if the receiver stalls,
// the next set is still collected, and only its result waits for the slot.
// Config channel cfg_*: the exponent, written between sets; always ready.
// Reset empties the cells, zeroes the count and sets the exponent to one.
module top_two_alpha_split (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tta_pkg::IN_TDATA_W-1:0]      s_tdata,   // weight
	input  logic                                s_tlast,   // is_last
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// winner_index, winner_alpha, runner_up_index, runner_up_alpha
	output logic [tta_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [tta_pkg::STAT_W-1:0]          m_tuser,   // status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tta_pkg::EXP_W-1:0]           cfg_data   // exponent
);

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_CHECK,
		ST_DIV1,
		ST_POW,
		ST_MUL,
		ST_DIV2,
		ST_OUT
	} state_t;

	state_t                              state_q;
	logic [tta_pkg::EXP_W-1:0]           exp_q;
	logic [tta_pkg::CNT_W-1:0]           count_q;
	logic [tta_pkg::Q_W-1:0]             ratio_q;
	logic [tta_pkg::S_W-1:0]             pow_q;
	logic [tta_pkg::S_W+tta_pkg::Q_W-1:0] prod_s1;
	logic [tta_pkg::EXP_W-1:0]           k_q;
	logic [tta_pkg::ALPHA_W-1:0]         win_alpha_q;
	logic [tta_pkg::ALPHA_W-1:0]         run_alpha_q;
	logic [tta_pkg::STAT_W-1:0]          stat_q;
	logic                                m_tvalid_q;
	logic [tta_pkg::OUT_TDATA_W-1:0]     m_tdata_q;
	logic [tta_pkg::STAT_W-1:0]          m_tuser_q;
	logic                                div_start_q;
	logic [tta_pkg::DIV_W-1:0]           div_rem_q;
	logic [tta_pkg::Q_W-1:0]             div_lo_q;
	logic [tta_pkg::DIV_W-1:0]           div_den_q;
	logic [tta_pkg::STEP_W-1:0]          div_steps_q;
	logic                                div_done;
	logic [tta_pkg::Q_W-1:0]             div_quot;

	logic                                accept;
	logic                                ins;
	logic                                clr;
	logic                                out_free;
	logic [tta_pkg::STAT_W-1:0]          stat_now;
	logic [tta_pkg::WEIGHT_BITS-1:0]     w_top;
	logic [tta_pkg::WEIGHT_BITS-1:0]     w_run;
	logic [tta_pkg::WEIGHT_BITS-1:0]     w_third;
	logic [tta_pkg::S_W+8-1:0]           n255;
	tta_pkg::tta_entry_t                 new_entry;
	tta_pkg::tta_entry_t                 cell_entry [tta_pkg::N_CELLS];
	tta_pkg::tta_entry_t                 cell_prev  [tta_pkg::N_CELLS];
	logic                                cell_take  [tta_pkg::N_CELLS];
	logic                                cell_ptake [tta_pkg::N_CELLS];

	assign s_tready  = (state_q == ST_COLLECT);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign accept   = s_tvalid && s_tready;
	assign ins      = accept && (count_q < tta_pkg::CNT_W'(tta_pkg::MAX_ITEMS));
	assign out_free = !m_tvalid_q || m_tready;
	assign clr      = (state_q == ST_OUT) && out_free;

	assign new_entry = '{valid: 1'b1,
		weight: s_tdata[tta_pkg::WEIGHT_BITS-1:0],
		index: count_q[tta_pkg::IDX_W-1:0]};

	// row of ranking cells, rank 0 highest
	for (genvar i = 0; i < tta_pkg::N_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_prev[i]  = '0;
			assign cell_ptake[i] = 1'b0;
		end else begin : g_link
			assign cell_prev[i]  = cell_entry[i-1];
			assign cell_ptake[i] = cell_take[i-1];
		end
		tta_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ins        (ins),
			.clr        (clr),
			.new_entry  (new_entry),
			.prev_entry (cell_prev[i]),
			.prev_take  (cell_ptake[i]),
			.take       (cell_take[i]),
			.entry      (cell_entry[i])
		);
	end

	tta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.rem_init (div_rem_q),
		.num_lo   (div_lo_q),
		.divisor  (div_den_q),
		.steps    (div_steps_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// set status and the three ranked weights
	always_comb begin
		if (count_q > tta_pkg::CNT_W'(tta_pkg::MAX_ITEMS)) begin
			stat_now = tta_pkg::STAT_TOO_MANY;
		end else if (count_q < tta_pkg::CNT_W'(tta_pkg::N_CELLS)) begin
			stat_now = tta_pkg::STAT_TOO_FEW;
		end else begin
			stat_now = tta_pkg::STAT_OK;
		end
	end
	assign w_top   = cell_entry[0].weight;
	assign w_run   = cell_entry[1].weight;
	assign w_third = cell_entry[2].weight;

	// 255 * s as a shift and subtract
	assign n255 = {pow_q, 8'b0} - {8'b0, pow_q};

	// exponent register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= tta_pkg::EXP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			exp_q <= cfg_data;
		end
	end

	// set count, saturating one past capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (ins) begin
			count_q <= count_q + 1'b1;
		end else if (accept) begin
			count_q <= tta_pkg::CNT_W'(tta_pkg::MAX_ITEMS + 1);
		end
	end

	// result sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			m_tvalid_q  <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			// start pulse lasts one cycle; it is never raised in the cycle after
			if (div_start_q) begin
				div_start_q <= 1'b0;
			end
			// ST_OUT reloads the slot itself
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (accept && s_tlast) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					stat_q <= stat_now;
					if (stat_now != tta_pkg::STAT_OK) begin
						win_alpha_q <= '0;
						run_alpha_q <= '0;
						state_q     <= ST_OUT;
					end else if (w_top == w_third || w_top == w_run) begin
						win_alpha_q <= tta_pkg::ALPHA_TIE_WIN;
						run_alpha_q <= tta_pkg::ALPHA_TIE_RUN;
						state_q     <= ST_OUT;
					end else begin
						// ratio (r-b)/(w-b) in Q0.16
						div_start_q <= 1'b1;
						div_rem_q   <= tta_pkg::DIV_W'(w_run - w_third);
						div_lo_q    <= '0;
						div_den_q   <= tta_pkg::DIV_W'(w_top - w_third);
						div_steps_q <= tta_pkg::STEP_W'(tta_pkg::Q_W);
						state_q     <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						ratio_q <= div_quot;
						pow_q   <= tta_pkg::S_W'(1) << tta_pkg::Q_W;
						k_q     <= '0;
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (k_q == exp_q) begin
						// share = 255*s / (1.0 + s), quotient below 256
						div_start_q <= 1'b1;
						div_rem_q   <= tta_pkg::DIV_W'(n255[tta_pkg::S_W+8-1:8]);
						div_lo_q    <= {n255[7:0], 8'b0};
						div_den_q   <= (tta_pkg::DIV_W'(1) << tta_pkg::Q_W)
							+ tta_pkg::DIV_W'(pow_q);
						div_steps_q <= tta_pkg::STEP_W'(8);
						state_q     <= ST_DIV2;
					end else begin
						prod_s1 <= pow_q * ratio_q;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// truncating product, back to Q1.16
					pow_q   <= prod_s1[tta_pkg::S_W+tta_pkg::Q_W-1:tta_pkg::Q_W];
					k_q     <= k_q + 1'b1;
					state_q <= ST_POW;
				end
				ST_DIV2: begin
					if (div_done) begin
						run_alpha_q <= div_quot[tta_pkg::ALPHA_W-1:0];
						win_alpha_q <= tta_pkg::ALPHA_FULL - div_quot[tta_pkg::ALPHA_W-1:0];
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= stat_q;
						if (stat_q == tta_pkg::STAT_OK) begin
							m_tdata_q <= {run_alpha_q, cell_entry[1].index,
								win_alpha_q, cell_entry[0].index};
						end else begin
							m_tdata_q <= '0;
						end
						state_q <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// ranks 0 and 1 stay in descending order
	a_cell_order: assert property (@(posedge clk) disable iff (!arst_n)
		cell_entry[1].valid |-> (cell_entry[0].weight >= cell_entry[1].weight))
		else $error("cells out of order");

	// a filled rank 2 has ranks 0 and 1 filled above it
	a_cell_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cell_entry[2].valid |-> (cell_entry[1].valid && cell_entry[0].valid))
		else $error("gap in ranked cells");

	// a good result splits the full alpha between the two
	a_alpha_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == tta_pkg::STAT_OK) |->
		(({1'b0, m_tdata[15:8]} + {1'b0, m_tdata[31:24]}) == 9'd255))
		else $error("alphas do not sum to full scale");

	// runner-up never outweighs the winner
	a_run_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == tta_pkg::STAT_OK) |-> (m_tdata[31:24] <= 8'd127))
		else $error("runner-up alpha above half");

endmodule

// ===== hw/rtl/tta_cell.sv =====
`timescale 1ns / 1ps

// One rank of the top-three list: takes the new entry or the one handed
// down from the rank above, and hands its own old entry to the rank below.
module tta_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ins,
	input  logic               clr,
	input  tta_pkg::tta_entry_t new_entry,
	input  tta_pkg::tta_entry_t prev_entry,
	input  logic               prev_take,
	output logic               take,
	output tta_pkg::tta_entry_t entry
);

	logic                            valid_q;
	logic [tta_pkg::WEIGHT_BITS-1:0] weight_q;
	logic [tta_pkg::IDX_W-1:0]       index_q;

	// new weight belongs here or above; later index wins on equal weights
	assign take  = !valid_q || (new_entry.weight >= weight_q);
	assign entry = '{valid: valid_q, weight: weight_q, index: index_q};

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (ins) begin
			if (prev_take) begin
				valid_q <= prev_entry.valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ins) begin
			if (prev_take) begin
				weight_q <= prev_entry.weight;
				index_q  <= prev_entry.index;
			end else if (take) begin
				weight_q <= new_entry.weight;
				index_q  <= new_entry.index;
			end
		end
	end

endmodule

// ===== hw/rtl/tta_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle. The caller supplies the
// upper part of the dividend (already below the divisor) and the low bits.
module tta_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tta_pkg::DIV_W-1:0]     rem_init,
	input  logic [tta_pkg::Q_W-1:0]       num_lo,
	input  logic [tta_pkg::DIV_W-1:0]     divisor,
	input  logic [tta_pkg::STEP_W-1:0]    steps,
	output logic                          done,
	output logic [tta_pkg::Q_W-1:0]       quot
);

	logic                         busy_q;
	logic [tta_pkg::STEP_W-1:0]   cnt_q;
	logic [tta_pkg::DIV_W-1:0]    rem_q;
	logic [tta_pkg::DIV_W-1:0]    div_q;
	logic [tta_pkg::Q_W-1:0]      num_q;
	logic [tta_pkg::Q_W-1:0]      quot_q;
	logic [tta_pkg::DIV_W:0]      trial;
	logic [tta_pkg::DIV_W:0]      diff;
	logic                         ge;
	logic                         step;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, num_q[tta_pkg::Q_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};
	assign step  = busy_q && (cnt_q != '0);
	assign done  = busy_q && (cnt_q == '0);
	assign quot  = quot_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num_lo;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (step) begin
			rem_q  <= ge ? diff[tta_pkg::DIV_W-1:0] : trial[tta_pkg::DIV_W-1:0];
			num_q  <= {num_q[tta_pkg::Q_W-2:0], 1'b0};
			quot_q <= {quot_q[tta_pkg::Q_W-2:0], ge};
		end
	end

endmodule

// ===== bench/tta_split_checker.sv =====
`timescale 1ns / 1ps

// Watches the weight, result and exponent channels of the top-two split block,
// ranks each weight taken within capacity itself and checks each result
// against its own prediction for the set.
module tta_split_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [tta_pkg::IN_TDATA_W-1:0]  s_tdata,   // weight
	input  logic                            s_tlast,   // is_last
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// winner_index, winner_alpha, runner_up_index, runner_up_alpha
	input  logic [tta_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [tta_pkg::STAT_W-1:0]      m_tuser,   // status
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tta_pkg::EXP_W-1:0]       cfg_data,  // exponent
	output int                              pending,
	output int                              fails
);

	import tta_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]   win_idx;
		logic [ALPHA_W-1:0] win_alpha;
		logic [IDX_W-1:0]   run_idx;
		logic [ALPHA_W-1:0] run_alpha;
		logic [STAT_W-1:0]  status;
	} split_t;

	// best three of the current set, rank 0 highest
	logic [WEIGHT_BITS-1:0] rank_w [N_CELLS];
	logic [IDX_W-1:0]       rank_i [N_CELLS];
	int unsigned            taken;
	logic [EXP_W-1:0]       power = 4'd1;
	split_t                 awaited_splits [$];
	split_t                 want;
	int                     fail_cnt = 0;

	task automatic clear_set();
		int i;
		for (i = 0; i < N_CELLS; i++) begin
			rank_w[i] = '0;
			rank_i[i] = '0;
		end
		taken = 0;
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_cnt++;
		end
	endtask

	// rank one weight; on the last of a set work out the split it should give
	task automatic take_weight(input logic [WEIGHT_BITS-1:0] w, input logic last);
		int unsigned filled, pos, i;
		split_t      res;
		logic [63:0] top_w, mid_w, low_w, ratio, scaled, share;
		if (taken < MAX_ITEMS) begin
			filled = (taken < N_CELLS) ? taken : N_CELLS;
			pos = filled;
			// first rank it beats or equals; equal weights put the newer one ahead
			for (i = filled; i > 0; i--)
				if (w >= rank_w[i-1])
					pos = i - 1;
			if (pos < N_CELLS) begin
				for (i = N_CELLS - 1; i > pos; i--) begin
					rank_w[i] = rank_w[i-1];
					rank_i[i] = rank_i[i-1];
				end
				rank_w[pos] = w;
				rank_i[pos] = 8'(taken);
			end
			taken++;
		end else begin
			taken = MAX_ITEMS + 1;
		end
		if (last) begin
			res = '0;
			if (taken > MAX_ITEMS) begin
				res.status = STAT_TOO_MANY;
			end else if (taken < N_CELLS) begin
				res.status = STAT_TOO_FEW;
			end else begin
				res.status  = STAT_OK;
				res.win_idx = rank_i[0];
				res.run_idx = rank_i[1];
				top_w = 64'(rank_w[0]);
				mid_w = 64'(rank_w[1]);
				low_w = 64'(rank_w[2]);
				if (top_w == low_w || top_w == mid_w) begin
					// no margin to split on
					res.win_alpha = ALPHA_TIE_WIN;
					res.run_alpha = ALPHA_TIE_RUN;
				end else begin
					ratio  = ((mid_w - low_w) << 16) / (top_w - low_w);
					scaled = 64'd65536;
					for (i = 0; i < power; i++)
						scaled = (scaled * ratio) >> 16;
					share = (64'd255 * scaled) / (64'd65536 + scaled);
					if (share > 64'd255)
						share = 64'd255;
					res.run_alpha = share[7:0];
					res.win_alpha = ALPHA_FULL - share[7:0];
				end
			end
			awaited_splits.push_back(res);
			clear_set();
		end
	endtask

	// follow all three channels; compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			power = 4'd1;
			awaited_splits.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				power = cfg_data;
			if (s_tvalid && s_tready)
				take_weight(s_tdata[WEIGHT_BITS-1:0], s_tlast);
			if (m_tvalid && m_tready) begin
				if (awaited_splits.size() == 0) begin
					$error("result request with no set outstanding: tdata %h tuser %0d",
						m_tdata, m_tuser);
					fail_cnt++;
				end else begin
					want = awaited_splits.pop_front();
					check_field("winner_index", want.win_idx, m_tdata[7:0]);
					check_field("winner_alpha", want.win_alpha, m_tdata[15:8]);
					check_field("runner_up_index", want.run_idx, m_tdata[23:16]);
					check_field("runner_up_alpha", want.run_alpha, m_tdata[31:24]);
					check_field("status", want.status, m_tuser);
				end
			end
		end
		pending <= awaited_splits.size();
		fails   <= fail_cnt;
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import tta_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 80;   // longest result latency with room to spare
	localparam int HOLD_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // weight
	logic                   s_tlast;   // is_last
	logic                   m_tvalid;
	logic                   m_tready;
	// winner_index, winner_alpha, runner_up_index, runner_up_alpha
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]      m_tuser;   // status
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [EXP_W-1:0]       cfg_data;  // exponent

	int pending;
	int fails;
	int hold_req;
	int cycles;

	top_two_alpha_split dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	tta_split_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.pending  (pending),
		.fails    (fails)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send_item(input logic [IN_TDATA_W-1:0] w, input logic last,
			input int gap);
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one set of random weights, biased towards extremes and ties
	task automatic send_set(input int len, input bit calm, input bit peak_last);
		logic [IN_TDATA_W-1:0] w, prev;
		int n, sel;
		prev = '0;
		for (n = 0; n < len; n++) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: w = '0;
				1: w = '1;
				2: w = prev;
				3: w = 16'($urandom_range(0, 3));
				4: w = 16'hFFFF - 16'($urandom_range(0, 3));
				default: w = 16'($urandom_range(0, 65535));
			endcase
			if (peak_last && n == len - 1)
				w = '1;
			send_item(w, n == len - 1, calm ? 0 : pick_gap());
			prev = w;
		end
	endtask

	// wait for every outstanding split, then let the block run dry
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_exponent(input logic [EXP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, calm stretches, and one long hold on request
	initial begin
		int stall_left;
		int hold_seen;
		bit calm_rx;
		stall_left = 0;
		hold_seen  = 0;
		calm_rx    = 1'b0;
		m_tready  <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0)
				calm_rx = !calm_rx;
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm_rx && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[top_two_alpha_split] ERROR");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int ph, sent, len, r;
		logic [EXP_W-1:0] next_exp;
		hold_req   = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// exponent from reset; top weight tied, the later one must win
		send_item(16'hFFFF, 1'b0, pick_gap());
		send_item(16'h0000, 1'b0, pick_gap());
		send_item(16'h8000, 1'b0, pick_gap());
		send_item(16'hFFFF, 1'b1, pick_gap());
		// plain ordering
		send_item(16'd100, 1'b0, pick_gap());
		send_item(16'd300, 1'b0, pick_gap());
		send_item(16'd200, 1'b1, pick_gap());
		// too few weights, one and two
		send_item(16'd7, 1'b1, pick_gap());
		send_item(16'h0000, 1'b0, pick_gap());
		send_item(16'hFFFF, 1'b1, pick_gap());
		// all equal: no margin over the third
		send_item(16'h0000, 1'b0, pick_gap());
		send_item(16'h0000, 1'b0, pick_gap());
		send_item(16'h0000, 1'b1, pick_gap());
		// runner-up right under the winner, third at zero
		send_item(16'hFFFF, 1'b0, pick_gap());
		send_item(16'hFFFE, 1'b0, pick_gap());
		send_item(16'h0000, 1'b1, pick_gap());
		// exponent zero
		settle();
		write_exponent(4'd0);
		send_item(16'd10, 1'b0, pick_gap());
		send_item(16'd20, 1'b0, pick_gap());
		send_item(16'd5, 1'b1, pick_gap());
		// largest exponent
		settle();
		write_exponent(4'd15);
		send_item(16'd1000, 1'b0, pick_gap());
		send_item(16'd999, 1'b0, pick_gap());
		send_item(16'd0, 1'b1, pick_gap());

		// a full set ending on index 255, then one weight over capacity
		send_set(MAX_ITEMS, 1'b0, 1'b1);
		send_set(MAX_ITEMS + 1, 1'b1, 1'b0);

		// random sets over several exponents; the first phase starts with a long hold
		// and sends short sets so that results pile up behind it
		for (ph = 0; ph < 5; ph++) begin
			settle();
			if (ph == 0)
				next_exp = 4'd1;
			else if (ph == 4)
				next_exp = 4'd15;
			else
				next_exp = 4'($urandom_range(1, 15));
			write_exponent(next_exp);
			if (ph == 0)
				hold_req <= hold_req + 1;
			sent = 0;
			while (sent < ((ph == 0) ? 16 : 6)) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					len = $urandom_range(1, 2);
				else if (r < 90 || ph == 0)
					len = $urandom_range(3, 5);
				else
					len = $urandom_range(6, 12);
				send_set(len, $urandom_range(0, 3) == 0, 1'b0);
				sent += len;
			end
		end

		settle();
		if (fails == 0)
			$display("[top_two_alpha_split] OK");
		else
			$display("[top_two_alpha_split] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tta_pkg.sv
hw/rtl/tta_cell.sv
hw/rtl/tta_div.sv
hw/rtl/top_two_alpha_split.sv
bench/tta_split_checker.sv
bench/tb.sv
